// ===== sv/cv3_pkg.sv =====
// ----------------------------------------------------------------------------
// cv3_pkg: shared types and constants of the 3x3 convolution filter
// Geometry limits, kernel table, divisor reciprocals and stage structs.
// ----------------------------------------------------------------------------
package cv3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int DIM_W      = 11;                  // image_width / image_height fields
    localparam int COL_W      = $clog2(MAX_WIDTH);   // column index into the line store
    localparam int ROW_W      = DIM_W;               // row counter, reaches image_height
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int LINE_W     = 2 * PIX_W;           // upper and middle row of one column
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;

    localparam int TAPS       = 9;
    localparam int COEF_W     = 5;
    localparam int SUM_W      = 14;
    localparam int QUO_IN_W   = 12;                  // sums that reach the reciprocal path
    localparam int RECIP_W    = 16;
    localparam int RECIP_SHIFT = 16;
    localparam int QUO_W      = QUO_IN_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_9 = 16'd7282;   // ceil(2^16 / 9)
    localparam logic [RECIP_W-1:0] RECIP_3 = 16'd21846;  // ceil(2^16 / 3)

    localparam int CH_MAX     = 255;

    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [2:0] {
        FILT_IDENTITY = 3'd0,
        FILT_SMOOTH   = 3'd1,
        FILT_BLUR     = 3'd2,
        FILT_SHARPEN  = 3'd3,
        FILT_MEAN     = 3'd4,
        FILT_EMBOSS   = 3'd5
    } filt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2,
        CFG_COLOR  = 2'd3
    } cfg_idx_t;

    // Rows top to bottom, three taps each, left to right.
    localparam logic signed [COEF_W-1:0] KERN [6][TAPS] = '{
        '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd0},
        '{ 5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1},
        '{ 5'sd1,  5'sd2,  5'sd1,  5'sd2,  5'sd4,  5'sd2,  5'sd1,  5'sd2,  5'sd1},
        '{ 5'sd0, -5'sd2,  5'sd0, -5'sd2,  5'sd11, -5'sd2, 5'sd0, -5'sd2,  5'sd0},
        '{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd9, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
        '{ 5'sd0, -5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd1,  5'sd0}
    };

    // One window column, index 0 top row, 2 bottom row.
    typedef logic [2:0][PIX_W-1:0] wcol_t;

    typedef struct packed {
        logic [TAPS-1:0][PIX_W-1:0] tap;   // tap[row*3 + col]
        logic                       row_end;
        logic                       frame_end;
    } tapset_t;

    typedef struct packed {
        logic [CH_W-1:0] c;
        logic [CH_W-1:0] b;
        logic [CH_W-1:0] a;
        logic            row_end;
        logic            frame_end;
    } result_t;

    // Unused selector codes fall back to identity.
    function automatic filt_t eff_filter(logic [2:0] code);
        filt_t f;
        if (code > 3'(FILT_EMBOSS)) begin
            f = FILT_IDENTITY;
        end else begin
            f = filt_t'(code);
        end
        return f;
    endfunction

endpackage

// ===== sv/cv3_ram.sv =====
// ----------------------------------------------------------------------------
// cv3_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cv3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/cv3_mac.sv =====
// ----------------------------------------------------------------------------
// cv3_mac: kernel arithmetic for one tap window per clock
// Products, adder tree, then divide by the kernel divisor and clamp to 0..255.
// ----------------------------------------------------------------------------
module cv3_mac (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  cv3_pkg::tapset_t  in_taps,
    input  cv3_pkg::filt_t    filt,
    input  logic              color_mode,
    output logic              out_valid,
    output cv3_pkg::result_t  out_res,
    output logic [1:0]        occupancy
);

    logic                                  p1_valid_reg;
    logic                                  p1_row_end_reg;
    logic                                  p1_frame_end_reg;
    logic signed [cv3_pkg::SUM_W-1:0]      prod_reg  [3][cv3_pkg::TAPS];
    logic signed [cv3_pkg::SUM_W-1:0]      prod_next [3][cv3_pkg::TAPS];

    logic                                  p2_valid_reg;
    logic                                  p2_row_end_reg;
    logic                                  p2_frame_end_reg;
    logic signed [cv3_pkg::SUM_W-1:0]      sum_reg  [3];
    logic signed [cv3_pkg::SUM_W-1:0]      sum_next [3];

    logic [cv3_pkg::CH_W-1:0]              chan_out [3];

    // Divide by the kernel divisor (exact for every sum below the clamp limit).
    function automatic logic [cv3_pkg::CH_W-1:0] scale_clamp(
        logic signed [cv3_pkg::SUM_W-1:0] s,
        cv3_pkg::filt_t                   f
    );
        logic signed [cv3_pkg::SUM_W-1:0] lim;
        logic [cv3_pkg::RECIP_W-1:0]      recip;
        logic [cv3_pkg::QUO_W-1:0]        prod;
        logic [cv3_pkg::CH_W-1:0]         q;
        unique case (f)
            cv3_pkg::FILT_SMOOTH:  lim = cv3_pkg::SUM_W'(cv3_pkg::CH_MAX * 9);
            cv3_pkg::FILT_BLUR:    lim = cv3_pkg::SUM_W'(cv3_pkg::CH_MAX * 16);
            cv3_pkg::FILT_SHARPEN: lim = cv3_pkg::SUM_W'(cv3_pkg::CH_MAX * 3);
            default:               lim = cv3_pkg::SUM_W'(cv3_pkg::CH_MAX);
        endcase
        recip = (f == cv3_pkg::FILT_SMOOTH) ? cv3_pkg::RECIP_9 : cv3_pkg::RECIP_3;
        prod  = cv3_pkg::QUO_W'(s[cv3_pkg::QUO_IN_W-1:0]) * cv3_pkg::QUO_W'(recip);
        unique case (f)
            cv3_pkg::FILT_SMOOTH,
            cv3_pkg::FILT_SHARPEN: q = prod[cv3_pkg::RECIP_SHIFT +: cv3_pkg::CH_W];
            cv3_pkg::FILT_BLUR:    q = s[4 +: cv3_pkg::CH_W];
            default:               q = s[cv3_pkg::CH_W-1:0];
        endcase
        priority if (s >= lim) begin
            q = cv3_pkg::CH_W'(cv3_pkg::CH_MAX);
        end else if (s[cv3_pkg::SUM_W-1] || s == '0) begin
            q = '0;
        end
        return q;
    endfunction

    // Stage 1: weight every tap of every channel.
    always_comb begin
        logic signed [cv3_pkg::SUM_W-1:0] pv;
        for (int ch = 0; ch < 3; ch++) begin
            for (int t = 0; t < cv3_pkg::TAPS; t++) begin
                pv = $signed(cv3_pkg::SUM_W'(in_taps.tap[t][ch*cv3_pkg::CH_W +: cv3_pkg::CH_W]));
                prod_next[ch][t] = pv * cv3_pkg::SUM_W'(cv3_pkg::KERN[filt][t]);
            end
        end
    end

    // Stage 2: adder tree per channel.
    always_comb begin
        logic signed [cv3_pkg::SUM_W-1:0] acc;
        for (int ch = 0; ch < 3; ch++) begin
            acc = '0;
            for (int t = 0; t < cv3_pkg::TAPS; t++) begin
                acc = acc + prod_reg[ch][t];
            end
            sum_next[ch] = acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
        end
        p1_row_end_reg   <= in_taps.row_end;
        p1_frame_end_reg <= in_taps.frame_end;
        prod_reg         <= prod_next;
        p2_row_end_reg   <= p1_row_end_reg;
        p2_frame_end_reg <= p1_frame_end_reg;
        sum_reg          <= sum_next;
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            chan_out[ch] = scale_clamp(sum_reg[ch], filt);
        end
    end

    assign out_valid         = p2_valid_reg;
    assign out_res.a         = chan_out[0];
    assign out_res.b         = color_mode ? chan_out[1] : '0;
    assign out_res.c         = color_mode ? chan_out[2] : '0;
    assign out_res.row_end   = p2_row_end_reg;
    assign out_res.frame_end = p2_frame_end_reg;
    assign occupancy         = 2'(p1_valid_reg) + 2'(p2_valid_reg);

endmodule

// ===== sv/conv3x3_image_filter.sv =====
// ----------------------------------------------------------------------------
// conv3x3_image_filter: streaming 3x3 convolution over raster-order pixels
// Line store in one RAM, tap window, kernel pipeline and a result FIFO.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while s_tready is high. Results lag the input by
// one row and one column; after the last image row, feed one flush row of
// image_width items (s_tuser high) to drain the last output row, after which
// a new frame starts. The last column of every output row yields two results
// from one item (one when the image is one column wide), and the single
// tap-window stage builds one result window per clock, so s_tready drops
// in the cycle after such an item. A pixel reaches m_tvalid through the line
// RAM read, window, products, adder tree and result FIFO registers. The
// 16-entry result FIFO lets input continue while the downstream side stalls;
// s_tready falls when the FIFO plus the results still in the pipeline could
// not take two more. The line RAM needs no clearing pass: entries from an
// earlier frame are masked as outside the image.
// ----------------------------------------------------------------------------
module conv3x3_image_filter (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cv3_pkg::PIX_W-1:0]        s_tdata,   // chan_a [7:0], chan_b [15:8], chan_c [23:16]
    input  logic                             s_tuser,   // action

    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cv3_pkg::PIX_W-1:0]        m_tdata,   // out_a [7:0], out_b [15:8], out_c [23:16]
    output logic                             m_tlast,   // row_end
    output logic                             m_tuser,   // frame_end

    input  logic                             cfg_wr_en,
    input  logic [cv3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cv3_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    // Configuration
    logic [2:0]                  filter_reg;
    logic [cv3_pkg::DIM_W-1:0]   width_reg;
    logic [cv3_pkg::DIM_W-1:0]   height_reg;
    logic                        color_reg;

    // Position counters
    logic [cv3_pkg::COL_W-1:0]   col_reg;
    logic [cv3_pkg::ROW_W-1:0]   row_reg;

    logic [cv3_pkg::DIM_W-1:0]   w_eff;
    logic [cv3_pkg::DIM_W-1:0]   h_eff;
    logic [cv3_pkg::COL_W-1:0]   cur_col;
    logic                        cur_flush;
    logic                        cur_last;
    logic                        s_acc;
    logic                        take;

    // Window stage
    logic                        s1_valid_reg;
    logic                        s1_phase_reg;
    logic [cv3_pkg::COL_W-1:0]   s1_col_reg;
    logic [cv3_pkg::PIX_W-1:0]   s1_px_reg;
    logic                        s1_flush_reg;
    logic                        s1_top_ok_reg;
    logic                        s1_cge1_reg;
    logic                        s1_cge2_reg;
    logic                        s1_e0_reg;
    logic                        s1_e1_reg;
    logic                        s1_busy;
    logic [1:0]                  s1_pend;

    // Line RAM and write-back forwarding
    logic                        ram_we;
    logic [cv3_pkg::LINE_W-1:0]  ram_wdata;
    logic [cv3_pkg::LINE_W-1:0]  ram_rdata;
    logic                        wr_valid_reg;
    logic [cv3_pkg::COL_W-1:0]   wr_addr_reg;
    logic [cv3_pkg::LINE_W-1:0]  wr_data_reg;
    logic [cv3_pkg::LINE_W-1:0]  line_word;
    logic [cv3_pkg::PIX_W-1:0]   line_up;
    logic [cv3_pkg::PIX_W-1:0]   line_mid;

    cv3_pkg::wcol_t              win_reg  [3];
    cv3_pkg::wcol_t              win_next [3];

    logic                        tv_reg;
    logic                        tv_next;
    cv3_pkg::tapset_t            taps_reg;
    cv3_pkg::tapset_t            taps_next;

    // Arithmetic and result FIFO
    cv3_pkg::filt_t              filt;
    logic                        res_valid;
    cv3_pkg::result_t            res;
    logic [1:0]                  mac_occ;
    logic [2:0]                  inflight;
    logic [5:0]                  need;

    cv3_pkg::result_t            fifo_reg [cv3_pkg::FIFO_DEPTH];
    logic [cv3_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [cv3_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [cv3_pkg::FIFO_AW:0]   fifo_cnt_reg;
    logic                        m_acc;
    cv3_pkg::result_t            head;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_reg <= 3'(cv3_pkg::FILT_IDENTITY);
            width_reg  <= cv3_pkg::DIM_W'(1024);
            height_reg <= cv3_pkg::DIM_W'(1024);
            color_reg  <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cv3_pkg::cfg_idx_t'(cfg_index))
                cv3_pkg::CFG_FILTER: filter_reg <= cfg_wdata[2:0];
                cv3_pkg::CFG_WIDTH:  width_reg  <= cfg_wdata;
                cv3_pkg::CFG_HEIGHT: height_reg <= cfg_wdata;
                cv3_pkg::CFG_COLOR:  color_reg  <= cfg_wdata[0];
            endcase
        end
    end

    assign filt = cv3_pkg::eff_filter(filter_reg);

    // ------------------------------------------------------------------
    // Input position
    // ------------------------------------------------------------------
    always_comb begin
        priority if (width_reg == '0) begin
            w_eff = cv3_pkg::DIM_W'(1);
        end else if (width_reg > cv3_pkg::DIM_W'(cv3_pkg::MAX_WIDTH)) begin
            w_eff = cv3_pkg::DIM_W'(cv3_pkg::MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        priority if (height_reg == '0) begin
            h_eff = cv3_pkg::DIM_W'(1);
        end else if (height_reg > cv3_pkg::DIM_W'(cv3_pkg::MAX_HEIGHT)) begin
            h_eff = cv3_pkg::DIM_W'(cv3_pkg::MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
        if (cv3_pkg::DIM_W'(col_reg) >= w_eff) begin
            cur_col = cv3_pkg::COL_W'(w_eff - cv3_pkg::DIM_W'(1));
        end else begin
            cur_col = col_reg;
        end
    end

    assign cur_flush = row_reg >= h_eff;
    assign cur_last  = cv3_pkg::DIM_W'(cur_col) == (w_eff - cv3_pkg::DIM_W'(1));
    assign s_acc     = s_tvalid && s_tready;
    // Drop flush items that arrive inside the image
    assign take      = s_acc && !(s_tuser && !cur_flush);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (take) begin
            if (cur_last) begin
                col_reg <= '0;
                row_reg <= cur_flush ? '0 : row_reg + cv3_pkg::ROW_W'(1);
            end else begin
                col_reg <= cur_col + cv3_pkg::COL_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Window stage: one result window per clock
    // ------------------------------------------------------------------
    assign s1_busy = s1_valid_reg && !s1_phase_reg && s1_e0_reg && s1_e1_reg;

    always_comb begin
        if (!s1_valid_reg) begin
            s1_pend = 2'd0;
        end else if (s1_phase_reg) begin
            s1_pend = 2'd1;
        end else begin
            s1_pend = 2'(s1_e0_reg) + 2'(s1_e1_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_phase_reg <= 1'b0;
        end else if (take) begin
            s1_valid_reg <= 1'b1;
            s1_phase_reg <= 1'b0;
        end else if (s1_busy) begin
            s1_phase_reg <= 1'b1;
        end else begin
            s1_valid_reg <= 1'b0;
            s1_phase_reg <= 1'b0;
        end
        if (take) begin
            s1_col_reg    <= cur_col;
            s1_px_reg     <= cur_flush ? '0 : s_tdata;
            s1_flush_reg  <= cur_flush;
            s1_top_ok_reg <= row_reg >= cv3_pkg::ROW_W'(2);
            s1_cge1_reg   <= cur_col >= cv3_pkg::COL_W'(1);
            s1_cge2_reg   <= cur_col >= cv3_pkg::COL_W'(2);
            s1_e0_reg     <= (row_reg != '0) && (cur_col != '0);
            s1_e1_reg     <= (row_reg != '0) && cur_last;
        end
    end

    cv3_ram #(
        .WIDTH (cv3_pkg::LINE_W),
        .DEPTH (cv3_pkg::MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (s1_col_reg),
        .wr_data (ram_wdata),
        .rd_en   (take),
        .rd_addr (cur_col),
        .rd_data (ram_rdata)
    );

    // The previous item writes the same column at the edge this item read it
    assign line_word = (wr_valid_reg && wr_addr_reg == s1_col_reg) ? wr_data_reg : ram_rdata;
    assign line_up   = line_word[cv3_pkg::LINE_W-1:cv3_pkg::PIX_W];
    assign line_mid  = line_word[cv3_pkg::PIX_W-1:0];
    assign ram_we    = s1_valid_reg && !s1_phase_reg && !s1_flush_reg;
    assign ram_wdata = {line_mid, s1_px_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_valid_reg <= 1'b0;
        end else if (ram_we) begin
            wr_valid_reg <= 1'b1;
        end
        if (ram_we) begin
            wr_addr_reg <= s1_col_reg;
            wr_data_reg <= ram_wdata;
        end
    end

    always_comb begin
        win_next = win_reg;
        if (s1_valid_reg && !s1_phase_reg) begin
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
            win_next[2] = {s1_px_reg, line_mid, line_up};
        end
    end

    // Regular result uses window columns 0..2; the row-end result uses 1..2
    // with the column beyond the edge as zero.
    always_comb begin
        logic use_e1;
        logic row_ok;
        logic col_ok;
        use_e1 = s1_phase_reg || !s1_e0_reg;
        for (int r = 0; r < 3; r++) begin
            row_ok = (r != 0 || s1_top_ok_reg) && (r != 2 || !s1_flush_reg);
            for (int j = 0; j < 3; j++) begin
                if (use_e1) begin
                    col_ok = (j == 0) ? s1_cge1_reg : (j == 1);
                    taps_next.tap[r*3 + j] = (row_ok && col_ok) ?
                                             win_next[(j == 0) ? 1 : 2][r] : '0;
                end else begin
                    col_ok = (j != 0) || s1_cge2_reg;
                    taps_next.tap[r*3 + j] = (row_ok && col_ok) ? win_next[j][r] : '0;
                end
            end
        end
        taps_next.row_end   = use_e1;
        taps_next.frame_end = use_e1 && s1_flush_reg;
        tv_next = s1_valid_reg && (s1_phase_reg || s1_e0_reg || s1_e1_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tv_reg <= 1'b0;
        end else begin
            tv_reg <= tv_next;
        end
        win_reg  <= win_next;
        taps_reg <= taps_next;
    end

    cv3_mac u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (tv_reg),
        .in_taps    (taps_reg),
        .filt       (filt),
        .color_mode (color_reg),
        .out_valid  (res_valid),
        .out_res    (res),
        .occupancy  (mac_occ)
    );

    // ------------------------------------------------------------------
    // Result FIFO and input credit
    // ------------------------------------------------------------------
    assign inflight = 3'(s1_pend) + 3'(tv_reg) + 3'(mac_occ);
    assign need     = 6'(fifo_cnt_reg) + 6'(inflight) + 6'd2;
    assign s_tready = !s1_busy && (need <= 6'(cv3_pkg::FIFO_DEPTH));

    assign m_acc    = m_tvalid && m_tready;
    assign m_tvalid = fifo_cnt_reg != '0;
    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tdata  = {head.c, head.b, head.a};
    assign m_tlast  = head.row_end;
    assign m_tuser  = head.frame_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (res_valid) begin
                wr_ptr_reg <= wr_ptr_reg + cv3_pkg::FIFO_AW'(1);
            end
            if (m_acc) begin
                rd_ptr_reg <= rd_ptr_reg + cv3_pkg::FIFO_AW'(1);
            end
            unique case ({res_valid, m_acc})
                2'b10:   fifo_cnt_reg <= fifo_cnt_reg + (cv3_pkg::FIFO_AW+1)'(1);
                2'b01:   fifo_cnt_reg <= fifo_cnt_reg - (cv3_pkg::FIFO_AW+1)'(1);
                default: fifo_cnt_reg <= fifo_cnt_reg;
            endcase
        end
        if (res_valid) begin
            fifo_reg[wr_ptr_reg] <= res;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        (7'(fifo_cnt_reg) + 7'(inflight)) <= 7'(cv3_pkg::FIFO_DEPTH))
        else $error("results in flight exceed FIFO room");

    a_fifo_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (fifo_cnt_reg < (cv3_pkg::FIFO_AW+1)'(cv3_pkg::FIFO_DEPTH)))
        else $error("result written into full FIFO");

    a_second: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_phase_reg) |->
            $past(s1_valid_reg && !s1_phase_reg && s1_e0_reg && s1_e1_reg))
        else $error("second row-end result without a two-result item");

    a_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("frame end on an item that is not a row end");

endmodule
